// File: rtl/ikarm_pkg.sv
// Shared types, constants and helper functions of the two-link arm inverse kinematics block.
package ikarm_pkg;

    // Fixed-point angle format and CORDIC depth.
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int TAB_BITS        = 24;
    localparam int TAB_LEN         = 24;
    localparam int STAGE_W         = $clog2(TAB_LEN);
    localparam int ACC_W           = ANGLE_FRAC_BITS + 10;
    localparam int SUM_W           = ACC_W + 2;

    // Datapath widths of the vector and square-root chains.
    localparam int VEC_W      = 42;
    localparam int RAD_W      = 64;
    localparam int SQRT_CELLS = RAD_W / 2;
    localparam int REM_W      = SQRT_CELLS + 2;

    // Cycles from an accepted request to its result strobe.
    localparam int PIPE_LAT = 5 + SQRT_CELLS + 1 + CORDIC_STAGES + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_ANGLE  = 8'd3;

    // Base pulse: (4500 + 50*a) / 9 by multiplying with a rounded-up reciprocal.
    localparam logic [13:0] PULSE_RECIP = 14'd14564;
    localparam int          PULSE_SHIFT = 17;

    // Fixed angles used by the quadrant handling.
    localparam logic signed [ACC_W-1:0] DEG_90  = ACC_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] DEG_180 = ACC_W'(180) <<< ANGLE_FRAC_BITS;

    // atan(2^-i) in degrees scaled by 2^24, rounded to nearest.
    localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    typedef struct packed {
        logic signed [11:0] target_x;
        logic signed [11:0] target_y;
        logic signed [11:0] target_z;
    } t_target;

    typedef struct packed {
        logic [11:0] base_pulse_us;
        logic [7:0]  shoulder_deg;
        logic [7:0]  wrist_deg;
        logic [7:0]  grip_deg;
        logic        unreachable;
    } t_servo;

    // One CORDIC vector with its angle accumulator; hold marks an axis case.
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
        logic                    hold;
    } t_vec;

    // One square-root lane: remaining radicand bits, remainder and partial root.
    typedef struct packed {
        logic [RAD_W-1:0]      rad;
        logic [REM_W-1:0]      rem;
        logic [SQRT_CELLS-1:0] root;
    } t_sqrt;

    // Arctangent step of one CORDIC cell, cut to the angle format.
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [STAGE_W-1:0] idx);
        logic [29:0] raw;
        raw = (idx < STAGE_W'(TAB_LEN)) ? ATAN_TAB[idx] : '0;
        return $signed(ACC_W'(raw >> (TAB_BITS - ANGLE_FRAC_BITS)));
    endfunction

    // Sign extension of an accumulator to the sum width.
    function automatic logic signed [SUM_W-1:0] widen(input logic signed [ACC_W-1:0] v);
        return SUM_W'(v);
    endfunction

    // Whole degrees, truncated toward zero.
    function automatic logic signed [SUM_W-1:0] trunc_deg(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] whole;
        mag   = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        whole = mag >> ANGLE_FRAC_BITS;
        return v[SUM_W-1] ? -$signed(whole) : $signed(whole);
    endfunction

    // Servo range limit.
    function automatic logic [7:0] sat180(input logic signed [SUM_W-1:0] v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 180) begin
            return 8'd180;
        end else begin
            return v[7:0];
        end
    endfunction

endpackage

// File: rtl/ikarm_sqrt_cell.sv
// One cell of the pipelined integer square root: resolves one root bit per cycle.
module ikarm_sqrt_cell import ikarm_pkg::*; (
    input  logic  i_clk,
    input  t_sqrt i_cell,
    output t_sqrt o_cell
);

    t_sqrt            r_cell;
    t_sqrt            n_cell;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             fit;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem2  = {i_cell.rem, i_cell.rad[RAD_W-1 -: 2]};
        trial = (REM_W+2)'({i_cell.root, 2'b01});
        fit   = (rem2 >= trial);
        n_cell.rem  = fit ? REM_W'(rem2 - trial) : REM_W'(rem2);
        n_cell.root = {i_cell.root[SQRT_CELLS-2:0], fit};
        n_cell.rad  = {i_cell.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

// File: rtl/ikarm_vec_prep.sv
// Quadrant handling ahead of a CORDIC chain: axis cases and turn into the right half plane.
module ikarm_vec_prep import ikarm_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [VEC_W-1:0] i_x,
    input  logic signed [VEC_W-1:0] i_y,
    output t_vec                    o_vec
);

    t_vec r_vec;
    t_vec n_vec;

    // Points on an axis get their angle directly and skip the rotations.
    always_comb begin
        n_vec.x    = i_x;
        n_vec.y    = i_y;
        n_vec.acc  = '0;
        n_vec.hold = 1'b0;
        priority if (i_y == 0) begin
            n_vec.hold = 1'b1;
            n_vec.acc  = (i_x < 0) ? DEG_180 : '0;
        end else if (i_x == 0) begin
            n_vec.hold = 1'b1;
            n_vec.acc  = (i_y > 0) ? DEG_90 : -DEG_90;
        end else if (i_x < 0) begin
            if (i_y > 0) begin
                n_vec.x   = i_y;
                n_vec.y   = -i_x;
                n_vec.acc = DEG_90;
            end else begin
                n_vec.x   = -i_y;
                n_vec.y   = i_x;
                n_vec.acc = -DEG_90;
            end
        end else begin
            n_vec.hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

// File: rtl/ikarm_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation toward the x axis per cycle.
module ikarm_cordic_cell import ikarm_pkg::*; (
    input  logic               i_clk,
    input  logic [STAGE_W-1:0] i_shift,
    input  t_vec               i_vec,
    output t_vec               o_vec
);

    t_vec                    r_vec;
    t_vec                    n_vec;
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [ACC_W-1:0] step;

    // Rotate against the sign of y and track the angle turned.
    always_comb begin
        x_in  = i_vec.x;
        y_in  = i_vec.y;
        xs    = x_in >>> i_shift;
        ys    = y_in >>> i_shift;
        step  = atan_step(i_shift);
        n_vec = i_vec;
        if (!i_vec.hold) begin
            if (y_in > 0) begin
                n_vec.x   = x_in + ys;
                n_vec.y   = y_in - xs;
                n_vec.acc = i_vec.acc + step;
            end else begin
                n_vec.x   = x_in - ys;
                n_vec.y   = y_in + xs;
                n_vec.acc = i_vec.acc - step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

// File: rtl/two_link_arm_inverse_kinematics.sv
// Top level: inverse kinematics of a base-rotating two-link arm, fully pipelined.
// Pipeline: a result strobes once its request has passed 5 front stages,
// 32 square-root cells, 1 quadrant stage, 16 CORDIC cells and 2 output stages.
// Throughput: one request per cycle while busy is low; the result strobe cannot be stalled.
// Reset (synchronous, active low) loads the register defaults and empties the pipeline;
// busy stays high and cfg ready stays low until the cycle after reset is released.
module two_link_arm_inverse_kinematics import ikarm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_target               i_target,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_strobe,
    output t_servo                o_servo
);

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic               zpos;
        logic signed [26:0] n1;
        logic signed [26:0] n2;
        logic signed [12:0] zoff;
        logic signed [11:0] x;
        logic signed [11:0] y;
    } t_side;

    typedef struct packed {
        logic valid;
        logic ok;
        logic zpos;
    } t_tail;

    // Configuration registers and run flag.
    logic       r_run;
    logic [9:0] r_base_height;
    logic [9:0] r_upper_link;
    logic [9:0] r_lower_link;
    logic [7:0] r_grip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run         <= 1'b0;
            r_base_height <= 10'd60;
            r_upper_link  <= 10'd120;
            r_lower_link  <= 10'd120;
            r_grip        <= 8'd88;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_BASE_HEIGHT: r_base_height <= i_cfg_data;
                    REG_UPPER_LINK:  r_upper_link  <= i_cfg_data;
                    REG_LOWER_LINK:  r_lower_link  <= i_cfg_data;
                    REG_GRIP_ANGLE:  r_grip        <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy        = !r_run;
    assign o_cfg_ready = r_run;

    // Stage A: capture the request.
    logic    r_a_valid;
    t_target r_a_tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
        r_a_tgt <= i_target;
    end

    // Stage B: height offset and the squares of the coordinates and links.
    logic               r_b_valid;
    logic signed [11:0] r_b_x;
    logic signed [11:0] r_b_y;
    logic signed [12:0] r_b_zoff;
    logic [22:0]        r_b_xx;
    logic [22:0]        r_b_yy;
    logic [23:0]        r_b_zz;
    logic [19:0]        r_b_l1sq;
    logic [19:0]        r_b_l2sq;
    logic signed [12:0] n_b_zoff;
    logic signed [23:0] prod_xx;
    logic signed [23:0] prod_yy;
    logic signed [25:0] prod_zz;
    logic [19:0]        n_b_l1sq;
    logic [19:0]        n_b_l2sq;

    always_comb begin
        n_b_zoff = $signed({r_a_tgt.target_z[11], r_a_tgt.target_z})
                 - $signed({3'b000, r_base_height});
        prod_xx  = r_a_tgt.target_x * r_a_tgt.target_x;
        prod_yy  = r_a_tgt.target_y * r_a_tgt.target_y;
        prod_zz  = n_b_zoff * n_b_zoff;
        n_b_l1sq = r_upper_link * r_upper_link;
        n_b_l2sq = r_lower_link * r_lower_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_x    <= r_a_tgt.target_x;
        r_b_y    <= r_a_tgt.target_y;
        r_b_zoff <= n_b_zoff;
        r_b_xx   <= prod_xx[22:0];
        r_b_yy   <= prod_yy[22:0];
        r_b_zz   <= prod_zz[23:0];
        r_b_l1sq <= n_b_l1sq;
        r_b_l2sq <= n_b_l2sq;
    end

    // Stage C: squared reach and the two law-of-cosines numerators.
    logic               r_c_valid;
    logic signed [11:0] r_c_x;
    logic signed [11:0] r_c_y;
    logic signed [12:0] r_c_zoff;
    logic [23:0]        r_c_d2;
    logic [24:0]        r_c_r2;
    logic signed [26:0] r_c_n1;
    logic signed [26:0] r_c_n2;
    logic [19:0]        r_c_l1sq;
    logic [19:0]        r_c_l2sq;
    logic [23:0]        n_c_d2;
    logic [24:0]        n_c_r2;

    always_comb begin
        n_c_d2 = 24'(r_b_xx) + 24'(r_b_yy);
        n_c_r2 = 25'(n_c_d2) + 25'(r_b_zz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_x    <= r_b_x;
        r_c_y    <= r_b_y;
        r_c_zoff <= r_b_zoff;
        r_c_d2   <= n_c_d2;
        r_c_r2   <= n_c_r2;
        r_c_n1   <= $signed(27'(r_b_l1sq)) + $signed(27'(n_c_r2)) - $signed(27'(r_b_l2sq));
        r_c_n2   <= $signed(27'(r_b_l1sq)) + $signed(27'(r_b_l2sq)) - $signed(27'(n_c_r2));
        r_c_l1sq <= r_b_l1sq;
        r_c_l2sq <= r_b_l2sq;
    end

    // Stage D: squared numerators and squared denominators.
    logic               r_d_valid;
    logic signed [11:0] r_d_x;
    logic signed [11:0] r_d_y;
    logic signed [12:0] r_d_zoff;
    logic [23:0]        r_d_d2;
    logic               r_d_r2_nz;
    logic signed [26:0] r_d_n1;
    logic signed [26:0] r_d_n2;
    logic [51:0]        r_d_n1sq;
    logic [51:0]        r_d_n2sq;
    logic [46:0]        r_d_dd1;
    logic [41:0]        r_d_dd2;
    logic signed [53:0] sq_n1;
    logic signed [53:0] sq_n2;
    logic [44:0]        prod_r2l1;
    logic [39:0]        prod_l1l2;

    always_comb begin
        sq_n1     = r_c_n1 * r_c_n1;
        sq_n2     = r_c_n2 * r_c_n2;
        prod_r2l1 = r_c_r2 * r_c_l1sq;
        prod_l1l2 = r_c_l1sq * r_c_l2sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_x     <= r_c_x;
        r_d_y     <= r_c_y;
        r_d_zoff  <= r_c_zoff;
        r_d_d2    <= r_c_d2;
        r_d_r2_nz <= (r_c_r2 != '0);
        r_d_n1    <= r_c_n1;
        r_d_n2    <= r_c_n2;
        r_d_n1sq  <= sq_n1[51:0];
        r_d_n2sq  <= sq_n2[51:0];
        r_d_dd1   <= {prod_r2l1, 2'b00};
        r_d_dd2   <= {prod_l1l2, 2'b00};
    end

    // Stage E: reach test and the three radicands.
    t_side       r_side_e;
    t_sqrt       r_e_sq [3];
    logic        n_ok;
    logic [46:0] e1;
    logic [41:0] e2;

    always_comb begin
        n_ok = r_d_r2_nz && (r_upper_link != '0) && (r_lower_link != '0)
            && (r_d_n1sq <= 52'(r_d_dd1)) && (r_d_n2sq <= 52'(r_d_dd2));
        e1 = r_d_dd1 - r_d_n1sq[46:0];
        e2 = r_d_dd2 - r_d_n2sq[41:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_e.valid <= 1'b0;
        end else begin
            r_side_e.valid <= r_d_valid;
        end
        r_side_e.ok   <= n_ok;
        r_side_e.zpos <= (r_d_zoff > 0);
        r_side_e.n1   <= r_d_n1;
        r_side_e.n2   <= r_d_n2;
        r_side_e.zoff <= r_d_zoff;
        r_side_e.x    <= r_d_x;
        r_side_e.y    <= r_d_y;
        r_e_sq[0].rad  <= n_ok ? RAD_W'({e1, 16'b0}) : '0;
        r_e_sq[1].rad  <= n_ok ? RAD_W'({e2, 16'b0}) : '0;
        r_e_sq[2].rad  <= RAD_W'({r_d_d2, 32'b0});
        r_e_sq[0].rem  <= '0;
        r_e_sq[1].rem  <= '0;
        r_e_sq[2].rem  <= '0;
        r_e_sq[0].root <= '0;
        r_e_sq[1].root <= '0;
        r_e_sq[2].root <= '0;
    end

    // Square-root chains: three lanes, one root bit per cell.
    t_sqrt w_sq [3][SQRT_CELLS+1];
    t_side r_side [SQRT_CELLS];

    for (genvar l = 0; l < 3; l++) begin : g_sq_lane
        assign w_sq[l][0] = r_e_sq[l];
        for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sq_cell
            ikarm_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_cell (w_sq[l][k]),
                .o_cell (w_sq[l][k+1])
            );
        end
    end

    // Side data travels alongside the square-root cells.
    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_side
        t_side n_side;
        if (k == 0) begin : g_first
            assign n_side = r_side_e;
        end else begin : g_next
            assign n_side = r_side[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= n_side;
            end
        end
    end

    // Quadrant stage: heading, shoulder triangle, elbow triangle, elevation.
    t_side                   side_q;
    logic signed [VEC_W-1:0] lane_x [4];
    logic signed [VEC_W-1:0] lane_y [4];
    t_vec                    w_vec [4][CORDIC_STAGES+1];
    t_tail                   r_tail [CORDIC_STAGES+1];

    always_comb begin
        side_q    = r_side[SQRT_CELLS-1];
        lane_x[0] = $signed({{(VEC_W-36){side_q.x[11]}}, side_q.x, 24'b0});
        lane_y[0] = $signed({{(VEC_W-36){side_q.y[11]}}, side_q.y, 24'b0});
        lane_x[1] = $signed({{(VEC_W-35){side_q.n1[26]}}, side_q.n1, 8'b0});
        lane_y[1] = $signed(VEC_W'(w_sq[0][SQRT_CELLS].root));
        lane_x[2] = $signed({{(VEC_W-35){side_q.n2[26]}}, side_q.n2, 8'b0});
        lane_y[2] = $signed(VEC_W'(w_sq[1][SQRT_CELLS].root));
        lane_x[3] = $signed(VEC_W'(w_sq[2][SQRT_CELLS].root));
        lane_y[3] = $signed({{(VEC_W-29){side_q.zoff[12]}}, side_q.zoff, 16'b0});
    end

    for (genvar l = 0; l < 4; l++) begin : g_vec_lane
        ikarm_vec_prep u_prep (
            .i_clk (i_clk),
            .i_x   (lane_x[l]),
            .i_y   (lane_y[l]),
            .o_vec (w_vec[l][0])
        );
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic_cell
            ikarm_cordic_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (STAGE_W'(i)),
                .i_vec   (w_vec[l][i]),
                .o_vec   (w_vec[l][i+1])
            );
        end
    end

    // Flags travel alongside the CORDIC cells.
    for (genvar i = 0; i <= CORDIC_STAGES; i++) begin : g_tail
        t_tail src_tail;
        if (i == 0) begin : g_first
            assign src_tail = {side_q.valid, side_q.ok, side_q.zpos};
        end else begin : g_next
            assign src_tail = r_tail[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tail[i].valid <= 1'b0;
            end else begin
                r_tail[i].valid <= src_tail.valid;
            end
            r_tail[i].ok   <= src_tail.ok;
            r_tail[i].zpos <= src_tail.zpos;
        end
    end

    // Stage Q1: heading to pulse numerator, raw shoulder and wrist angles.
    t_tail                   tail_f;
    logic                    r_q_valid;
    logic                    r_q_ok;
    logic [14:0]             r_q_v;
    logic signed [SUM_W-1:0] r_q_sh;
    logic signed [SUM_W-1:0] r_q_wr;
    logic signed [SUM_W-1:0] head_e;
    logic signed [SUM_W-1:0] theta_e;
    logic signed [SUM_W-1:0] beta_e;
    logic signed [SUM_W-1:0] phi_e;
    logic signed [SUM_W-1:0] head_t;
    logic signed [SUM_W-1:0] head_w;
    logic signed [SUM_W-1:0] ang_a;
    logic [14:0]             n_q_v;
    logic signed [SUM_W-1:0] n_q_sh;
    logic signed [SUM_W-1:0] n_q_wr;

    always_comb begin
        tail_f  = r_tail[CORDIC_STAGES];
        head_e  = widen(w_vec[0][CORDIC_STAGES].acc);
        theta_e = widen(w_vec[1][CORDIC_STAGES].acc);
        beta_e  = widen(w_vec[2][CORDIC_STAGES].acc);
        phi_e   = widen(w_vec[3][CORDIC_STAGES].acc);
        head_t  = trunc_deg(head_e);
        head_w  = (head_t < 0) ? SUM_W'(head_t + 360) : head_t;
        ang_a   = SUM_W'(head_w - 20);
        n_q_v   = 15'(ang_a * 50 + 4500);
        if (tail_f.zpos) begin
            n_q_sh = SUM_W'(((trunc_deg(phi_e) + 90) <<< ANGLE_FRAC_BITS) + theta_e);
            n_q_wr = SUM_W'(beta_e - (65 <<< ANGLE_FRAC_BITS));
        end else begin
            n_q_sh = SUM_W'(theta_e - phi_e);
            n_q_wr = beta_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= tail_f.valid;
        end
        r_q_ok <= tail_f.ok;
        r_q_v  <= n_q_v;
        r_q_sh <= n_q_sh;
        r_q_wr <= n_q_wr;
    end

    // Stage Q2: whole degrees, servo limits, pulse width and output register.
    logic        r_out_valid;
    t_servo      r_out;
    t_servo      n_out;
    logic [28:0] pulse_prod;

    always_comb begin
        pulse_prod          = 29'(r_q_v) * 29'(PULSE_RECIP);
        n_out.base_pulse_us = pulse_prod[PULSE_SHIFT +: 12];
        n_out.shoulder_deg  = r_q_ok ? sat180(trunc_deg(r_q_sh)) : 8'd0;
        n_out.wrist_deg     = r_q_ok ? sat180(trunc_deg(r_q_wr)) : 8'd0;
        n_out.grip_deg      = r_grip;
        n_out.unreachable   = !r_q_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_q_valid;
        end
        r_out <= n_out;
    end

    assign o_res_strobe = r_out_valid;
    assign o_servo      = r_out;

`ifndef SYNTH
    // Every request comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_res_strobe)
        else $error("result strobe missing after request");

    // No result appears without a request the pipeline latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without request");

    // An out-of-reach target leaves both joint angles at zero.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_servo.unreachable) |->
        (o_servo.shoulder_deg == 8'd0 && o_servo.wrist_deg == 8'd0))
        else $error("joint angles set on unreachable target");

    // Base pulse stays within the servo range.
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |->
        (o_servo.base_pulse_us >= 12'd388 && o_servo.base_pulse_us <= 12'd2384))
        else $error("base pulse out of range");
`endif

endmodule
